// ----- design/echo_request_timeout_tracker_macros.svh -----
// Assertion macros for the echo request timeout tracker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ECHO_REQUEST_TIMEOUT_TRACKER_MACROS_SVH
`define ECHO_REQUEST_TIMEOUT_TRACKER_MACROS_SVH

// same-cycle implication
`define ERTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ertt assertion failed");

// next-cycle implication
`define ERTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ertt assertion failed");

`endif

// ----- design/ertt_pkg.sv -----
// Types and constants of the echo request timeout tracker.
// Used by the tracker top level; no dependencies.
package ertt_pkg;

  localparam int ENTRIES = 16;
  localparam int MAX_OUT = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int N_W     = $clog2(MAX_OUT + 1);

  localparam logic [23:0] TIMEOUT_RST = 24'd1000;
  localparam logic [24:0] ELAPSED_CAP = 25'd16777216;

  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] KIND_SENT      = 3'd0;
  localparam logic [2:0] KIND_MATCH     = 3'd1;
  localparam logic [2:0] KIND_UNMATCHED = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] dest_addr;
    logic [15:0] reply_seq;
    logic [7:0]  client_id;
  } ertt_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  client_out;
    logic [31:0] addr_out;
    logic [15:0] seq_out;
    logic [24:0] elapsed;
    logic        last;
  } ertt_out_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] seq;
    logic [7:0]  client;
    logic [31:0] sent_at;
  } ertt_slot_t;

endpackage

// ----- design/ertt_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
module ertt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/echo_request_timeout_tracker.sv -----
// Echo request timeout tracker: slot table, scan sequencer, result register.
// Depends on ertt_pkg, ertt_ram and echo_request_timeout_tracker_macros.svh.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (ertt_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (ertt_out_t)
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (timeout_ticks)
//
// One shared index walks the slot RAM one slot a cycle; a send stops at the first free slot,
// a reply scans every slot and a send to a full table skips the scan.
// A tick scans for the oldest entry and rescans after each expired entry that it removes.
// in_stall_o is high except when idle; a stalled result holds off the next request.
// Reset empties the table at once; no clearing pass.
`include "echo_request_timeout_tracker_macros.svh"

module echo_request_timeout_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ertt_pkg::ertt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ertt_pkg::ertt_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i
);

  import ertt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  logic [2:0]        state_q, state_d, nxt_q, nxt_d;
  ertt_in_t          req_q, req_d;
  logic [23:0]       timeout_q, timeout_d;
  logic [31:0]       now_q, now_d;
  logic [15:0]       seq_q, seq_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RANK_W-1:0] rank_q [ENTRIES];
  logic [RANK_W-1:0] rank_d [ENTRIES];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d, chk_idx_q, chk_idx_d;
  logic              iss_q, iss_d, chk_vld_q, chk_vld_d;
  logic              best_fnd_q, best_fnd_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [RANK_W-1:0] best_rank_q, best_rank_d;
  ertt_slot_t        best_q, best_d;
  logic [N_W-1:0]    n_q, n_d;
  logic              pend_vld_q, pend_vld_d;
  ertt_out_t         pend_q, pend_d, out_q, out_d;

  logic              ram_we;
  ertt_slot_t        ram_wdata, ram_rdata;
  logic              start_scan, rm_en, chk_last, expired;
  logic [31:0]       age;
  logic [24:0]       age_sat;
  logic [RANK_W-1:0] rm_rank;
  ertt_out_t         res;
  logic              tick_beat;

  ertt_ram #(
    .WIDTH($bits(ertt_slot_t)),
    .DEPTH(ENTRIES)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(chk_idx_q),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;
  assign tick_beat   = (state_q == S_IDLE) && in_valid_i && (in_data_i.opcode == OP_TICK);

  always_comb begin
    state_d     = state_q;
    nxt_d       = nxt_q;
    req_d       = req_q;
    timeout_d   = timeout_q;
    now_d       = now_q;
    seq_d       = seq_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    count_d     = count_q;
    idx_d       = idx_q;
    iss_d       = iss_q;
    chk_idx_d   = chk_idx_q;
    chk_vld_d   = chk_vld_q;
    best_fnd_d  = best_fnd_q;
    best_idx_d  = best_idx_q;
    best_rank_d = best_rank_q;
    best_d      = best_q;
    n_d         = n_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_wdata   = '{addr: req_q.dest_addr, seq: seq_q, client: req_q.client_id,
                    sent_at: now_q};
    start_scan  = 1'b0;
    rm_en       = 1'b0;
    chk_last    = (chk_idx_q == IDX_LAST);
    age         = now_q - best_q.sent_at;
    age_sat     = (age > 32'(ELAPSED_CAP)) ? ELAPSED_CAP : age[24:0];
    expired     = (age > {8'd0, timeout_q});
    rm_rank     = best_rank_q;
    res         = '{kind: KIND_TIMEOUT, client_out: best_q.client, addr_out: best_q.addr,
                    seq_out: best_q.seq, elapsed: age_sat, last: 1'b0};

    if (cfg_we_i) begin
      timeout_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          case (in_data_i.opcode)
            OP_SEND: begin
              if (count_q == CNT_W'(ENTRIES)) begin
                out_d = '{kind: KIND_FULL, client_out: in_data_i.client_id,
                          addr_out: in_data_i.dest_addr, seq_out: 16'd0,
                          elapsed: 25'd0, last: 1'b1};
                nxt_d   = S_IDLE;
                state_d = S_OUT;
              end else begin
                start_scan = 1'b1;
              end
            end
            OP_REPLY: start_scan = 1'b1;
            OP_TICK: begin
              now_d      = now_q + 32'd1;
              n_d        = '0;
              pend_vld_d = 1'b0;
              start_scan = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (iss_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q;
          idx_d     = idx_q + 1'b1;
          iss_d     = (idx_q != IDX_LAST);
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          case (req_q.opcode)
            OP_SEND: begin
              if (!valid_q[chk_idx_q]) begin
                ram_we              = 1'b1;
                valid_d[chk_idx_q]  = 1'b1;
                rank_d[chk_idx_q]   = count_q[RANK_W-1:0];
                count_d             = count_q + 1'b1;
                seq_d               = seq_q + 16'd1;
                out_d = '{kind: KIND_SENT, client_out: req_q.client_id,
                          addr_out: req_q.dest_addr, seq_out: seq_q,
                          elapsed: 25'd0, last: 1'b1};
                nxt_d   = S_IDLE;
                state_d = S_OUT;
              end
            end
            OP_REPLY: begin
              if (valid_q[chk_idx_q] && (ram_rdata.addr == req_q.dest_addr) &&
                  (ram_rdata.seq == req_q.reply_seq) &&
                  (!best_fnd_q || (rank_q[chk_idx_q] < best_rank_q))) begin
                best_fnd_d  = 1'b1;
                best_idx_d  = chk_idx_q;
                best_rank_d = rank_q[chk_idx_q];
                best_d      = ram_rdata;
              end
              if (chk_last) begin
                if (best_fnd_d) begin
                  state_d = S_EVAL;
                end else begin
                  out_d = '{kind: KIND_UNMATCHED, client_out: 8'd0,
                            addr_out: req_q.dest_addr, seq_out: req_q.reply_seq,
                            elapsed: 25'd0, last: 1'b1};
                  nxt_d   = S_IDLE;
                  state_d = S_OUT;
                end
              end
            end
            default: begin
              if (valid_q[chk_idx_q] && (rank_q[chk_idx_q] == '0)) begin
                best_idx_d  = chk_idx_q;
                best_rank_d = '0;
                best_d      = ram_rdata;
                state_d     = S_EVAL;
              end else if (chk_last) begin
                state_d = pend_vld_q ? S_FLUSH : S_IDLE;
              end
            end
          endcase
        end
      end
      S_EVAL: begin
        if (req_q.opcode == OP_REPLY) begin
          rm_en = 1'b1;
          out_d = '{kind: KIND_MATCH, client_out: best_q.client, addr_out: best_q.addr,
                    seq_out: best_q.seq, elapsed: age_sat, last: 1'b1};
          nxt_d   = S_IDLE;
          state_d = S_OUT;
        end else if (expired) begin
          rm_en = 1'b1;
          n_d   = n_q + 1'b1;
          if (pend_vld_q) begin
            out_d   = pend_q;
            pend_d  = res;
            nxt_d   = ((n_q + 1'b1) == N_W'(MAX_OUT)) ? S_FLUSH : S_SCAN;
            state_d = S_OUT;
          end else begin
            pend_d     = res;
            pend_vld_d = 1'b1;
            if ((n_q + 1'b1) == N_W'(MAX_OUT)) begin
              state_d = S_FLUSH;
            end else begin
              start_scan = 1'b1;
            end
          end
        end else begin
          state_d = pend_vld_q ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        out_d      = pend_q;
        out_d.last = 1'b1;
        pend_vld_d = 1'b0;
        nxt_d      = S_IDLE;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (nxt_q == S_SCAN) begin
            start_scan = 1'b1;
          end else begin
            state_d = nxt_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (start_scan) begin
      state_d    = S_SCAN;
      idx_d      = '0;
      iss_d      = 1'b1;
      chk_vld_d  = 1'b0;
      best_fnd_d = 1'b0;
    end

    if (rm_en) begin
      valid_d[best_idx_q] = 1'b0;
      count_d             = count_q - 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] > rm_rank)) begin
          rank_d[i] = rank_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nxt_q      <= S_IDLE;
      timeout_q  <= TIMEOUT_RST;
      now_q      <= '0;
      seq_q      <= '0;
      valid_q    <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      iss_q      <= 1'b0;
      chk_vld_q  <= 1'b0;
      best_fnd_q <= 1'b0;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      nxt_q      <= nxt_d;
      timeout_q  <= timeout_d;
      now_q      <= now_d;
      seq_q      <= seq_d;
      valid_q    <= valid_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      iss_q      <= iss_d;
      chk_vld_q  <= chk_vld_d;
      best_fnd_q <= best_fnd_d;
      n_q        <= n_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rank_q      <= rank_d;
    chk_idx_q   <= chk_idx_d;
    best_idx_q  <= best_idx_d;
    best_rank_q <= best_rank_d;
    best_q      <= best_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  `ERTT_ASSERT_IMP(a_count_matches_valid, 1'b1, count_q == CNT_W'($countones(valid_q)))
  `ERTT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(ENTRIES))
  `ERTT_ASSERT_IMP(a_pend_only_tick, pend_vld_q && (state_q != S_IDLE), req_q.opcode == OP_TICK)
  `ERTT_ASSERT_IMP(a_expiry_bound, 1'b1, n_q <= N_W'(MAX_OUT))
  `ERTT_ASSERT_NXT(a_tick_advances, tick_beat, now_q == $past(now_q) + 32'd1)

endmodule
